FILE: src/tct_pkg.sv
// Shared types and constants of the touch contact tracker.
package tct_pkg;

    localparam int MAX_CONTACTS = 16;
    localparam int SLOT_W       = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CNT_W        = $clog2(MAX_CONTACTS + 1);
    localparam int PREC_W       = 15;

    localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(4);

    localparam logic       REQ_PURGE   = 1'b1;
    localparam logic [1:0] KIND_UP     = 2'd2;
    localparam logic [1:0] KIND_CANCEL = 2'd3;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_KEPT     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_PURGED   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic               req_type;
        logic [15:0]        contact_id;
        logic [1:0]         event_kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         slot;
        logic signed [15:0] held_x;
        logic signed [15:0] held_y;
        logic [1:0]         held_kind;
        logic [4:0]         removed_count;
        logic [4:0]         active_count;
    } t_out_item;

    // query travelling along the row of cells
    typedef struct packed {
        logic              vld;
        logic              purge;
        logic [15:0]       id;
        logic [1:0]        kind;
        logic [15:0]       x;
        logic [15:0]       y;
        logic              found;
        logic              upd;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       hx;
        logic [15:0]       hy;
        logic [1:0]        hk;
        logic              free_ok;
        logic [SLOT_W-1:0] free_slot;
        logic [CNT_W-1:0]  removed;
        logic [CNT_W-1:0]  active;
    } t_pkt;

    // insert broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       id;
        logic [1:0]        kind;
        logic [15:0]       x;
        logic [15:0]       y;
    } t_wr;

endpackage

FILE: src/tct_cell.sv
// One table slot: holds an entry and processes the passing query.
module tct_cell import tct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_idx,
    input  logic [PREC_W-1:0] i_prec,
    input  t_wr               i_wr,
    input  t_pkt              i_pkt,
    output t_pkt              o_pkt
);

    logic        r_valid;
    logic [15:0] r_id;
    logic [1:0]  r_kind;
    logic [15:0] r_x;
    logic [15:0] r_y;
    t_pkt        r_pkt;

    t_pkt        n_pkt;
    logic        match;
    logic        free;
    logic        purge_hit;
    logic        upd;
    logic        ins;
    logic [16:0] dx;
    logic [16:0] dy;
    logic [16:0] ax;
    logic [16:0] ay;

    always_comb begin
        dx        = {r_x[15], r_x} - {i_pkt.x[15], i_pkt.x};
        dy        = {r_y[15], r_y} - {i_pkt.y[15], i_pkt.y};
        ax        = dx[16] ? (17'd0 - dx) : dx;
        ay        = dy[16] ? (17'd0 - dy) : dy;
        upd       = (r_kind != i_pkt.kind) || (i_prec == '0) ||
                    (ax > {2'b00, i_prec}) || (ay > {2'b00, i_prec});
        match     = i_pkt.vld && !i_pkt.purge && r_valid && (r_id == i_pkt.id) &&
                    !i_pkt.found;
        free      = i_pkt.vld && !i_pkt.purge && !r_valid && !i_pkt.free_ok;
        purge_hit = i_pkt.vld && i_pkt.purge && r_valid &&
                    ((r_kind == KIND_UP) || (r_kind == KIND_CANCEL));
        ins       = i_wr.en && (i_wr.slot == i_idx);
    end

    always_comb begin
        n_pkt = i_pkt;
        if (match) begin
            n_pkt.found = 1'b1;
            n_pkt.upd   = upd;
            n_pkt.slot  = i_idx;
            n_pkt.hx    = upd ? i_pkt.x : r_x;
            n_pkt.hy    = upd ? i_pkt.y : r_y;
            n_pkt.hk    = upd ? i_pkt.kind : r_kind;
        end
        if (free) begin
            n_pkt.free_ok   = 1'b1;
            n_pkt.free_slot = i_idx;
        end
        n_pkt.removed = i_pkt.removed + CNT_W'(purge_hit);
        n_pkt.active  = i_pkt.active + CNT_W'(r_valid && !purge_hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ins) begin
            r_valid <= 1'b1;
        end else if (purge_hit) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins) begin
            r_id   <= i_wr.id;
            r_kind <= i_wr.kind;
            r_x    <= i_wr.x;
            r_y    <= i_wr.y;
        end else if (match && upd) begin
            r_kind <= i_pkt.kind;
            r_x    <= i_pkt.x;
            r_y    <= i_pkt.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= '0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

endmodule

FILE: src/tct_ctrl.sv
// Sequencer: injects queries, finishes inserts and holds the result beat.
module tct_ctrl import tct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    output t_pkt      o_inj,
    input  t_pkt      i_tail,
    output t_wr       o_wr
);

    t_state    r_state;
    t_state    n_state;
    t_pkt      r_res;
    logic      r_out_vld;
    t_out_item r_out;
    t_out_item n_out;

    logic      accept;
    logic      out_free;
    logic      fin_go;
    logic      ins;

    assign out_free = !r_out_vld || !i_out_stall;
    assign accept   = i_in_valid && !o_in_stall;
    assign ins      = !r_res.purge && !r_res.found && r_res.free_ok;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_RUN;
            S_RUN:   if (i_tail.vld) n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        fin_go     = (r_state == S_FIN) && out_free;
    end

    always_comb begin
        o_inj           = '0;
        o_inj.vld       = accept;
        o_inj.purge     = (i_in_data.req_type == REQ_PURGE);
        o_inj.id        = i_in_data.contact_id;
        o_inj.kind      = i_in_data.event_kind;
        o_inj.x         = i_in_data.pos_x;
        o_inj.y         = i_in_data.pos_y;

        o_wr      = '0;
        o_wr.en   = fin_go && ins;
        o_wr.slot = r_res.free_slot;
        o_wr.id   = r_res.id;
        o_wr.kind = r_res.kind;
        o_wr.x    = r_res.x;
        o_wr.y    = r_res.y;
    end

    always_comb begin
        n_out              = '0;
        n_out.active_count = 5'(r_res.active + CNT_W'(ins));
        priority if (r_res.purge) begin
            n_out.status        = ST_PURGED;
            n_out.removed_count = 5'(r_res.removed);
        end else if (r_res.found) begin
            n_out.status    = r_res.upd ? ST_UPDATED : ST_KEPT;
            n_out.slot      = 4'(r_res.slot);
            n_out.held_x    = r_res.hx;
            n_out.held_y    = r_res.hy;
            n_out.held_kind = r_res.hk;
        end else if (r_res.free_ok) begin
            n_out.status    = ST_INSERTED;
            n_out.slot      = 4'(r_res.free_slot);
            n_out.held_x    = r_res.x;
            n_out.held_y    = r_res.y;
            n_out.held_kind = r_res.kind;
        end else begin
            n_out.status = ST_DROPPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && i_tail.vld) begin
            r_res <= i_tail;
        end
        if (fin_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: src/touch_contact_tracker.sv
// Touch contact tracker: contact table kept in a row of slot cells.
// Each beat is a touch event or a purge. A query walks the row of MAX_CONTACTS
// slot cells one cell per cycle; each cell matches, updates, purges and counts
// its own entry as the query passes, and an insert into the lowest free slot is
// written at the end of the walk. A result passes through the cell row, is
// captured in the result register and is then registered at the output; the
// next item is taken once the result is registered, while that result may
// still wait at the output. A result still stalled at the output holds the
// next item at the end of its walk. The precision register may be written at
// any time the block is idle and is used by the next item.
module touch_contact_tracker import tct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [PREC_W-1:0] i_cfg_data
);

    logic [PREC_W-1:0]       r_prec;
    t_pkt                    w_pkt [MAX_CONTACTS+1];
    t_wr                     w_wr;
    logic [MAX_CONTACTS-1:0] w_vld;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prec <= PREC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_prec <= i_cfg_data;
        end
    end

    tct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_inj       (w_pkt[0]),
        .i_tail      (w_pkt[MAX_CONTACTS]),
        .o_wr        (w_wr)
    );

    for (genvar g = 0; g < MAX_CONTACTS; g++) begin : g_cell
        tct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SLOT_W'(g)),
            .i_prec  (r_prec),
            .i_wr    (w_wr),
            .i_pkt   (w_pkt[g]),
            .o_pkt   (w_pkt[g+1])
        );
        assign w_vld[g] = w_pkt[g+1].vld;
    end

`ifndef ASSERT_OFF
    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one query in the cell row");

    a_inject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_pkt[1].vld)
        else $error("accepted beat did not enter the first cell");

    a_insert_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (w_vld == '0) && !w_pkt[0].vld)
        else $error("insert while a query is in flight");
`endif

endmodule
